/* rtl/core/swec_pkg.sv */
// Package with the sizes, command codes and limits of the sliding-window event counter.
package swec_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TIMEOUT_W = 31;
  localparam int unsigned COUNT_W   = 5;

  localparam logic [COUNT_W-1:0]   COUNT_MAX       = '1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_DEFAULT = TIMEOUT_W'(1000);

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

endpackage

/* rtl/core/sliding_window_event_counter.sv */
// Sliding-window event counter: a slot table scanned one slot per cycle by a shared age unit.
//
// The block keeps SLOTS event timestamps, each with a valid bit. An item is
// accepted at a rising edge where start_i is high and busy_o is low; it holds
// a command (record or query) and the current time now_i.
// A record stores now_i in the lowest free slot, or else reuses the lowest slot
// whose age is strictly greater than the timeout; stored_o tells whether it did.
// A query returns in live_count_o how many valid slots are younger than the
// timeout and frees every other valid slot.
// One subtractor and two comparators form the shared age unit. The sequencer
// walks the table one slot per clock, scanning every slot for each item; the
// result appears on the cycle after the last scan, marked by a one-cycle
// done_o strobe. A new item can be accepted in the same cycle that done_o is
// high. The receiver cannot stall: each result is shown for exactly one cycle.
// The timeout register is written with window_timeout_we_i; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Reset empties the table at once and loads a timeout of 1000.
module sliding_window_event_counter
  import swec_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 command_i,
  input  logic [TIME_W-1:0]    now_i,
  input  logic                 window_timeout_we_i,
  input  logic [TIMEOUT_W-1:0] window_timeout_i,
  output logic                 done_o,
  output logic [COUNT_W-1:0]   live_count_o,
  output logic                 stored_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_e               state_q;
  cmd_e                 cmd_q;
  logic [TIME_W-1:0]    now_q;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [IDX_W-1:0]     idx_q;
  logic [COUNT_W-1:0]   count_q;
  logic                 free_found_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic                 exp_found_q;
  logic [IDX_W-1:0]     exp_idx_q;
  logic [SLOTS-1:0]     valid_q;
  logic [TIME_W-1:0]    slot_time_q [SLOTS];
  logic                 done_q;
  logic [COUNT_W-1:0]   live_count_q;
  logic                 stored_q;

  logic                 accept;
  logic                 last_slot;
  logic [TIME_W-1:0]    age;
  logic [TIME_W-1:0]    timeout_ext;
  logic                 cur_valid;
  logic                 cur_expired;
  logic                 cur_live;
  logic                 free_hit;
  logic [IDX_W-1:0]     free_idx;
  logic                 exp_hit;
  logic [IDX_W-1:0]     exp_idx;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;

  assign busy_o       = (state_q != ST_IDLE);
  assign accept       = start_i && !busy_o;
  assign last_slot    = (idx_q == LAST_IDX);

  // Shared age unit: one wrapping subtract and the compares against the timeout.
  assign age          = now_q - slot_time_q[idx_q];
  assign timeout_ext  = {1'b0, timeout_q};
  assign cur_valid    = valid_q[idx_q];
  assign cur_expired  = cur_valid && (age > timeout_ext);
  assign cur_live     = cur_valid && (age < timeout_ext);

  // Lowest free slot wins over the lowest expired one, so the scan keeps both.
  assign free_hit     = free_found_q || !cur_valid;
  assign free_idx     = free_found_q ? free_idx_q : idx_q;
  assign exp_hit      = exp_found_q || cur_expired;
  assign exp_idx      = exp_found_q ? exp_idx_q : idx_q;

  assign wr_en  = (state_q == ST_SCAN) && last_slot && (cmd_q == CMD_RECORD)
                  && (free_hit || exp_hit);
  assign wr_idx = free_hit ? free_idx : exp_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= CMD_RECORD;
      timeout_q    <= TIMEOUT_DEFAULT;
      idx_q        <= '0;
      count_q      <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      exp_found_q  <= 1'b0;
      exp_idx_q    <= '0;
      valid_q      <= '0;
      done_q       <= 1'b0;
      live_count_q <= '0;
      stored_q     <= 1'b0;
    end else begin
      if (window_timeout_we_i) begin
        timeout_q <= window_timeout_i;
      end
      case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (accept) begin
            state_q      <= ST_SCAN;
            cmd_q        <= cmd_e'(command_i);
            idx_q        <= '0;
            count_q      <= '0;
            free_found_q <= 1'b0;
            exp_found_q  <= 1'b0;
          end
        end
        ST_SCAN: begin
          free_found_q <= free_hit;
          free_idx_q   <= free_idx;
          exp_found_q  <= exp_hit;
          exp_idx_q    <= exp_idx;
          done_q       <= last_slot;
          if (cmd_q == CMD_QUERY) begin
            if (cur_live && (count_q != COUNT_MAX)) begin
              count_q <= count_q + COUNT_W'(1);
            end
            if (cur_valid && !cur_live) begin
              valid_q[idx_q] <= 1'b0;
            end
          end
          if (wr_en) begin
            valid_q[wr_idx] <= 1'b1;
          end
          if (last_slot) begin
            state_q  <= ST_IDLE;
            stored_q <= wr_en;
            if (cmd_q == CMD_QUERY) begin
              live_count_q <= (cur_live && (count_q != COUNT_MAX))
                              ? count_q + COUNT_W'(1) : count_q;
            end else begin
              live_count_q <= '0;
            end
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  // Timestamps carry no reset: a slot time is only read while its valid bit is set.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_time_q[wr_idx] <= now_q;
    end
  end

  // The current time is payload and is captured when an item is accepted.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= now_i;
    end
  end

  assign done_o       = done_q;
  assign live_count_o = live_count_q;
  assign stored_o     = stored_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while the scan is still running");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o && !done_o)
    else $error("accepted item did not start a scan");

  a_record_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (cmd_q == CMD_RECORD)) |-> (live_count_o == '0))
    else $error("record result carries a nonzero count");

  a_query_stored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (cmd_q == CMD_QUERY)) |-> !stored_o)
    else $error("query result claims a stored event");

  a_query_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (cmd_q == CMD_QUERY) && (SLOTS < 32))
      |-> (COUNT_W'($countones(valid_q)) == live_count_o))
    else $error("query count differs from the slots left valid");

endmodule

/* test/swec_window_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts each result of the sliding-window event counter and compares it.
module swec_window_checker
  import swec_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic                 command_i,
  input  logic [TIME_W-1:0]    now_i,
  input  logic                 window_timeout_we_i,
  input  logic [TIMEOUT_W-1:0] window_timeout_i,
  input  logic                 done_i,
  input  logic [COUNT_W-1:0]   live_count_i,
  input  logic                 stored_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o,
  output int unsigned          dropped_o
);

  typedef struct packed {
    logic [COUNT_W-1:0] live_count;
    logic               stored;
  } outcome_t;

  // Private copy of the slot table and of the timeout register.
  logic [TIME_W-1:0]    event_time [SLOTS];
  bit                   event_live [SLOTS];
  logic [TIMEOUT_W-1:0] expiry;

  outcome_t expected_outcomes [$];

  function automatic outcome_t predict_outcome(input cmd_e cmd, input logic [TIME_W-1:0] now);
    outcome_t          res;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] limit;
    bit                placed;
    res    = '0;
    limit  = TIME_W'(expiry);
    placed = 1'b0;
    if (cmd == CMD_RECORD) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !event_live[i]) begin
          event_live[i] = 1'b1;
          event_time[i] = now;
          placed = 1'b1;
        end
      end
      // Only reached with every slot valid, so every time read here was written.
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed) begin
          age = now - event_time[i];
          if (age > limit) begin
            event_time[i] = now;
            placed = 1'b1;
          end
        end
      end
      res.stored = placed;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (event_live[i]) begin
          age = now - event_time[i];
          if (age < limit) begin
            if (res.live_count != COUNT_MAX) res.live_count = res.live_count + 1'b1;
          end else begin
            event_live[i] = 1'b0;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    outcome_t oldest;
    outcome_t fresh;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) event_live[i] = 1'b0;
      expiry = TIMEOUT_DEFAULT;
      expected_outcomes.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      dropped_o    = 0;
    end else begin
      // The result of the previous item comes first: a new item may be taken on the same edge.
      if (done_i) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no item outstanding: live_count %0d, stored %0d",
                 live_count_i, stored_i);
          fail_count_o++;
        end else begin
          oldest = expected_outcomes.pop_front();
          checked_o++;
          if (live_count_i !== oldest.live_count) begin
            $error("live_count mismatch: expected %0d, actual %0d",
                   oldest.live_count, live_count_i);
            fail_count_o++;
          end
          if (stored_i !== oldest.stored) begin
            $error("stored mismatch: expected %0d, actual %0d", oldest.stored, stored_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        fresh = predict_outcome(cmd_e'(command_i), now_i);
        if (cmd_e'(command_i) == CMD_RECORD && !fresh.stored) dropped_o++;
        expected_outcomes.push_back(fresh);
      end
      if (window_timeout_we_i) expiry = window_timeout_i;
      pending_o = expected_outcomes.size();
    end
  end

endmodule

/* test/tb_sliding_window_event_counter.sv */
`timescale 1ns / 100ps
// Testbench top for the sliding-window event counter: stimulus, watchdog and verdict.
module tb_sliding_window_event_counter;
  import swec_pkg::*;

  // One item occupies the block for a full table scan, and its result follows the scan.
  localparam int unsigned ITEM_LATENCY    = SLOTS + 1;
  // Cycles without any accepted item or result before the run is declared hung.
  // The longest legal quiet stretch is a random sender gap plus one scan.
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned PHASES          = 11;
  localparam int unsigned ITEMS_PER_PHASE = 100;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic                 command_i;
  logic [TIME_W-1:0]    now_i;
  logic                 window_timeout_we_i;
  logic [TIMEOUT_W-1:0] window_timeout_i;
  logic                 done_o;
  logic [COUNT_W-1:0]   live_count_o;
  logic                 stored_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned dropped;

  // Stimulus-side bookkeeping: the running time line and the timeout now in force.
  logic [TIME_W-1:0]    stamp;
  logic [TIME_W-1:0]    recent_stamps [$];
  logic [TIMEOUT_W-1:0] timeout_now;
  bit                   no_idle;
  int unsigned          records_sent;
  int unsigned          queries_sent;
  int unsigned          settings_used;

  sliding_window_event_counter u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .command_i           (command_i),
    .now_i               (now_i),
    .window_timeout_we_i (window_timeout_we_i),
    .window_timeout_i    (window_timeout_i),
    .done_o              (done_o),
    .live_count_o        (live_count_o),
    .stored_o            (stored_o)
  );

  swec_window_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_i              (busy_o),
    .command_i           (command_i),
    .now_i               (now_i),
    .window_timeout_we_i (window_timeout_we_i),
    .window_timeout_i    (window_timeout_i),
    .done_i              (done_o),
    .live_count_i        (live_count_o),
    .stored_i            (stored_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .checked_o           (checked),
    .dropped_o           (dropped)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Presents one item from a falling edge and holds it until the block takes it.
  // Before that the sender may idle for a random number of cycles, with random
  // junk on the fields while start is low. Now and then a long gap is thrown in
  // so that the next item lands well after the block has gone idle.
  task automatic send_item(input cmd_e cmd, input logic [TIME_W-1:0] at);
    if (!no_idle) begin
      while ($urandom_range(99) < 37) begin
        start_i   <= 1'b0;
        command_i <= 1'($urandom_range(1));
        now_i     <= $urandom;
        if ($urandom_range(19) == 0) begin
          repeat ($urandom_range(40, 1)) @(negedge clk_i);
        end else begin
          @(negedge clk_i);
        end
      end
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    now_i     <= at;
    // The values read right after the edge are the ones the block saw at that edge.
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    if (cmd == CMD_RECORD) begin
      records_sent++;
      recent_stamps.push_back(at);
      if (recent_stamps.size() > SLOTS) void'(recent_stamps.pop_front());
    end else begin
      queries_sent++;
    end
  endtask

  // Writes the timeout register once the block has delivered every result it owes.
  task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
    start_i <= 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    window_timeout_we_i <= 1'b1;
    window_timeout_i    <= value;
    @(negedge clk_i);
    window_timeout_we_i <= 1'b0;
    window_timeout_i    <= TIMEOUT_W'($urandom);
    timeout_now = value;
    settings_used++;
  endtask

  // Moves the time line. Most steps are a fraction of the timeout, so ages cluster
  // around the expiry boundary; some aim at an age of exactly timeout-1, timeout or
  // timeout+1 for a recently recorded event, and a few jump or step backwards.
  function automatic logic [TIME_W-1:0] next_stamp();
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] target;
    logic [TIME_W-1:0] pick;
    target = TIME_W'(timeout_now);
    span   = (timeout_now == 0) ? TIME_W'(1) : target;
    case ($urandom_range(15))
      0: stamp = $urandom;
      1: stamp = stamp;
      2, 3: begin
        if (recent_stamps.size() > 0) begin
          pick  = recent_stamps[$urandom_range(recent_stamps.size() - 1)];
          stamp = pick + target + TIME_W'($urandom_range(2)) - TIME_W'(1);
        end
      end
      4: stamp = stamp - TIME_W'($urandom_range(3));
      default: stamp = stamp + ($urandom % (span / TIME_W'($urandom_range(8, 1)) + 1));
    endcase
    return stamp;
  endfunction

  // Watchdog: ends the run if neither an item nor a result moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o) quiet = 0;
      else quiet++;
    end
    $display("sliding_window_event_counter verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [TIMEOUT_W-1:0] setting;
    int unsigned          burst;
    cmd_e                 cmd;

    rst_ni              = 1'b0;
    start_i             = 1'b0;
    command_i           = 1'b0;
    now_i               = '0;
    window_timeout_we_i = 1'b0;
    window_timeout_i    = '0;
    stamp               = '0;
    timeout_now         = TIMEOUT_DEFAULT;
    no_idle             = 1'b0;
    records_sent        = 0;
    queries_sent        = 0;
    settings_used       = 1;
    burst               = 0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, first under the timeout loaded by reset.
    // A query on an empty table, then two records whose ages straddle the wrap of time.
    send_item(CMD_QUERY, 32'd0);
    send_item(CMD_RECORD, 32'd0);
    send_item(CMD_RECORD, 32'hFFFF_FFFF);
    send_item(CMD_QUERY, 32'd500);
    // One slot is exactly at the timeout and one just past it: both are freed, none counted.
    send_item(CMD_QUERY, 32'd1000);

    // Smallest timeout: fill the table, then show that an age equal to the timeout
    // cannot be reused while an age one beyond it can.
    write_timeout(TIMEOUT_W'(1));
    repeat (SLOTS) send_item(CMD_RECORD, 32'd50);
    send_item(CMD_RECORD, 32'd51);
    send_item(CMD_RECORD, 32'd52);
    send_item(CMD_QUERY, 32'd52);

    // Largest timeout: the surviving slot reaches an age of exactly the timeout.
    write_timeout('1);
    send_item(CMD_QUERY, 32'd52 + 32'h7FFF_FFFF);

    // Random part in phases, each with its own timeout; one phase runs with no idling.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: setting = TIMEOUT_W'(1);
        1: setting = '1;
        2: setting = '0;
        3: setting = TIMEOUT_W'($urandom_range(64, 2));
        4: setting = TIMEOUT_DEFAULT;
        default: setting = TIMEOUT_W'($urandom >> $urandom_range(31, 1));
      endcase
      write_timeout(setting);
      no_idle = (p == 5);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Bursts of records fill the table so that reuse and dropping get exercised.
        if (burst > 0) begin
          cmd = CMD_RECORD;
          burst--;
        end else if ($urandom_range(31) == 0) begin
          cmd   = CMD_RECORD;
          burst = $urandom_range(20, 10);
        end else begin
          cmd = ($urandom_range(99) < 60) ? CMD_RECORD : CMD_QUERY;
        end
        send_item(cmd, next_stamp());
      end
    end
    no_idle = 1'b0;
    start_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (2 * ITEM_LATENCY) @(negedge clk_i);

    $display("Covered %0d records and %0d queries under %0d timeout settings.",
             records_sent, queries_sent, settings_used);
    $display("Checked %0d results; %0d records found the table full and were dropped.",
             checked, dropped);
    if (fail_count == 0 && pending == 0) begin
      $display("sliding_window_event_counter verification clean");
    end else begin
      $display("sliding_window_event_counter verification failed");
    end
    $finish;
  end

endmodule
